// File: design/msc_pkg.sv
// ============================================================================
// msc_pkg - shared types and constants
// Word layout, per-channel statistics and helpers for the signature checker.
// ============================================================================
package msc_pkg;

    localparam int NUM_CHANNELS  = 32;
    localparam int POSITION_BITS = 20;
    localparam int COUNT_BITS    = 20;

    localparam int CH_W     = 5;
    localparam int WORD_W   = 32;
    localparam int EXP_W    = 16;
    localparam int OUT_W    = 20;
    localparam int SIG_LEN  = 7;
    localparam int HDR_LEN  = 8;
    localparam int WIN_LEN  = 22;
    localparam int FILL_W   = 5;
    localparam int SKIP_W   = 5;

    localparam logic [HDR_LEN-1:0]    HDR_CODE     = 8'hB1;
    localparam logic [SKIP_W-1:0]     SKIP_AFTER   = 5'd21;
    localparam logic [COUNT_BITS-1:0] CNT_MAX      = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] SPACING_FROM = COUNT_BITS'(2);

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                     judge;
        logic                     clear;
        logic [POSITION_BITS-1:0] pos;
    } t_lane_ctrl;

    typedef struct packed {
        logic [COUNT_BITS-1:0] headers;
        logic [COUNT_BITS-1:0] false_hdrs;
        logic [COUNT_BITS-1:0] sig_match;
        logic [COUNT_BITS-1:0] comp_local;
        logic [COUNT_BITS-1:0] comp_given;
        logic [COUNT_BITS-1:0] spacing_err;
        logic [SIG_LEN-1:0]    last_sig;
    } t_lane_stats;

    typedef struct packed {
        logic [CH_W-1:0]    read_channel;
        logic [OUT_W-1:0]   headers_found;
        logic [OUT_W-1:0]   false_headers;
        logic [OUT_W-1:0]   signature_matches;
        logic [OUT_W-1:0]   complement_local_matches;
        logic [OUT_W-1:0]   complement_given_matches;
        logic [OUT_W-1:0]   spacing_errors;
        logic [SIG_LEN-1:0] newest_signature;
    } t_result;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // counter to the 20-bit result field: zero-extend or keep the low bits
    function automatic logic [OUT_W-1:0] fit_out(input logic [COUNT_BITS-1:0] c);
        logic [63:0] t;
        t = 64'(c);
        return t[OUT_W-1:0];
    endfunction

endpackage

// File: design/msc_in_if.sv
// ============================================================================
// msc_in_if - input word channel
// Valid/ready channel carrying one command word: mode, snapshot, channel,
// expected value.
// ============================================================================
interface msc_in_if;
    import msc_pkg::*;

    logic                valid;
    logic                ready;
    t_mode               mode;
    logic [WORD_W-1:0]   sample_word;
    logic [CH_W-1:0]     channel;
    logic [EXP_W-1:0]    expected_value;

    modport source (output valid, output mode, output sample_word, output channel,
                    output expected_value, input ready);
    modport sink   (input valid, input mode, input sample_word, input channel,
                    input expected_value, output ready);
endinterface

// File: design/msc_out_if.sv
// ============================================================================
// msc_out_if - statistics word channel
// Valid/ready channel carrying one channel statistics word.
// ============================================================================
interface msc_out_if;
    import msc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    read_channel;
    logic [OUT_W-1:0]   headers_found;
    logic [OUT_W-1:0]   false_headers;
    logic [OUT_W-1:0]   signature_matches;
    logic [OUT_W-1:0]   complement_local_matches;
    logic [OUT_W-1:0]   complement_given_matches;
    logic [OUT_W-1:0]   spacing_errors;
    logic [SIG_LEN-1:0] newest_signature;

    modport source (output valid, output read_channel, output headers_found,
                    output false_headers, output signature_matches,
                    output complement_local_matches, output complement_given_matches,
                    output spacing_errors, output newest_signature, input ready);
    modport sink   (input valid, input read_channel, input headers_found,
                    input false_headers, input signature_matches,
                    input complement_local_matches, input complement_given_matches,
                    input spacing_errors, input newest_signature, output ready);
endinterface

// File: design/msc_lane.sv
// ============================================================================
// msc_lane - per-channel header and signature judge
// Holds one channel's expected value and statistics and judges the oldest
// window position from the channel's bit column.
// ============================================================================
module msc_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msc_pkg::t_lane_ctrl            i_ctrl,
    input  logic [msc_pkg::WIN_LEN-1:0]    i_column,
    input  logic                           i_load,
    input  logic [msc_pkg::EXP_W-1:0]      i_load_value,
    output msc_pkg::t_lane_stats           o_stats
);
    import msc_pkg::*;

    logic [EXP_W-1:0]         r_expected, n_expected;
    logic [SKIP_W-1:0]        r_skip, n_skip;
    logic [POSITION_BITS-1:0] r_last_pos, n_last_pos;
    logic [POSITION_BITS-1:0] r_last_space, n_last_space;
    t_lane_stats              r_stats, n_stats;

    logic [HDR_LEN-1:0]       hdr;
    logic [SIG_LEN-1:0]       sig1, sig2;
    logic [POSITION_BITS-1:0] gap;
    logic [COUNT_BITS-1:0]    hdr_cnt;

    // column slot 0 is the oldest word; bits are read MSB first
    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr[HDR_LEN-1-i] = i_column[i];
        end
        for (int i = 0; i < SIG_LEN; i++) begin
            sig1[SIG_LEN-1-i] = i_column[HDR_LEN+i];
            sig2[SIG_LEN-1-i] = i_column[HDR_LEN+SIG_LEN+i];
        end
    end

    assign gap     = i_ctrl.pos - r_last_pos;
    assign hdr_cnt = sat_inc(r_stats.headers);

    always_comb begin
        n_expected   = r_expected;
        n_skip       = r_skip;
        n_last_pos   = r_last_pos;
        n_last_space = r_last_space;
        n_stats      = r_stats;
        if (i_load) begin
            n_expected = i_load_value;
        end
        if (i_ctrl.clear) begin
            n_skip       = '0;
            n_last_pos   = '0;
            n_last_space = '0;
            n_stats      = '0;
        end else if (i_ctrl.judge && (r_expected != '0)) begin
            if (i_column[0] && (r_skip == '0)) begin
                if (hdr == HDR_CODE) begin
                    n_stats.headers = hdr_cnt;
                    if ((gap != r_last_space) && (hdr_cnt > SPACING_FROM)) begin
                        n_stats.spacing_err = sat_inc(r_stats.spacing_err);
                    end
                    n_last_space = gap;
                    n_last_pos   = i_ctrl.pos;
                    if (sig1 == r_expected[15:9]) begin
                        n_stats.sig_match = sat_inc(r_stats.sig_match);
                    end
                    if (sig1 == ~sig2) begin
                        n_stats.comp_local = sat_inc(r_stats.comp_local);
                    end
                    if (sig2 == r_expected[8:2]) begin
                        n_stats.comp_given = sat_inc(r_stats.comp_given);
                    end
                    n_skip           = SKIP_AFTER;
                    n_stats.last_sig = sig1;
                end else begin
                    n_stats.false_hdrs = sat_inc(r_stats.false_hdrs);
                end
            end else if (r_skip != '0) begin
                n_skip = r_skip - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_skip       <= '0;
            r_last_pos   <= '0;
            r_last_space <= '0;
            r_stats      <= '0;
        end else begin
            r_expected   <= n_expected;
            r_skip       <= n_skip;
            r_last_pos   <= n_last_pos;
            r_last_space <= n_last_space;
            r_stats      <= n_stats;
        end
    end

    assign o_stats = r_stats;

endmodule

// File: design/msc_merge.sv
// ============================================================================
// msc_merge - statistics select and output buffer
// Picks the addressed lane's statistics and holds result words in an output
// register backed by a skid register.
// ============================================================================
module msc_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msc_pkg::t_lane_stats   i_stats [msc_pkg::NUM_CHANNELS],
    input  logic                   i_push,
    input  logic [msc_pkg::CH_W-1:0] i_channel,
    output logic                   o_full,
    msc_out_if.source              o_out
);
    import msc_pkg::*;

    t_result     w_res;
    t_lane_stats w_sel;
    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;
    logic        w_pop;

    always_comb begin
        w_sel = '0;
        if (32'(i_channel) < NUM_CHANNELS) begin
            w_sel = i_stats[i_channel];
        end
        w_res.read_channel             = i_channel;
        w_res.headers_found            = fit_out(w_sel.headers);
        w_res.false_headers            = fit_out(w_sel.false_hdrs);
        w_res.signature_matches        = fit_out(w_sel.sig_match);
        w_res.complement_local_matches = fit_out(w_sel.comp_local);
        w_res.complement_given_matches = fit_out(w_sel.comp_given);
        w_res.spacing_errors           = fit_out(w_sel.spacing_err);
        w_res.newest_signature         = w_sel.last_sig;
    end

    assign w_pop = r_out_valid && o_out.ready;

    // a push never arrives while the skid register is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_full                         = r_skid_valid;
    assign o_out.valid                    = r_out_valid;
    assign o_out.read_channel             = r_out.read_channel;
    assign o_out.headers_found            = r_out.headers_found;
    assign o_out.false_headers            = r_out.false_headers;
    assign o_out.signature_matches        = r_out.signature_matches;
    assign o_out.complement_local_matches = r_out.complement_local_matches;
    assign o_out.complement_given_matches = r_out.complement_given_matches;
    assign o_out.spacing_errors           = r_out.spacing_errors;
    assign o_out.newest_signature         = r_out.newest_signature;

endmodule

// File: design/multichannel_signature_checker.sv
// ============================================================================
// multichannel_signature_checker - top level
// 22-word snapshot window feeding one judge lane per channel, with a merged
// statistics read port.
// ============================================================================
// Throughput: one word per cycle while i_in.ready is high; lanes with nonzero
// expected values judge in the same cycle. Read statistics are registered.
// i_in.ready drops only while both the output and skid registers hold words.
// Reset (i_rst_n low, synchronous) empties the window, zeroes the position,
// every statistic and every expected value; clear mode keeps expected values.
module multichannel_signature_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msc_in_if.sink     i_in,
    msc_out_if.source  o_out
);
    import msc_pkg::*;

    logic [WORD_W-1:0]        r_win [WIN_LEN];
    logic [WORD_W-1:0]        n_win [WIN_LEN];
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic [POSITION_BITS-1:0] r_pos;

    logic        w_acc, w_sample, w_clear, w_read, w_loadcmd, w_judge, w_full;
    t_lane_ctrl  w_ctrl;
    t_lane_stats w_stats [NUM_CHANNELS];
    logic [WIN_LEN-1:0] w_col [NUM_CHANNELS];

    assign i_in.ready = ~w_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_sample   = w_acc && (i_in.mode == MODE_SAMPLE);
    assign w_loadcmd  = w_acc && (i_in.mode == MODE_LOAD);
    assign w_read     = w_acc && (i_in.mode == MODE_READ);
    assign w_clear    = w_acc && (i_in.mode == MODE_CLEAR);

    // window after this word: shift once full, otherwise fill the next slot
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            if (r_fill == FILL_W'(WIN_LEN)) begin
                n_win[k] = r_win[k+1];
            end else begin
                n_win[k] = (r_fill == FILL_W'(k)) ? i_in.sample_word : r_win[k];
            end
        end
        n_win[WIN_LEN-1] = ((r_fill == FILL_W'(WIN_LEN)) ||
                            (r_fill == FILL_W'(WIN_LEN - 1))) ?
                           i_in.sample_word : r_win[WIN_LEN-1];
        n_fill = (r_fill == FILL_W'(WIN_LEN)) ? r_fill : r_fill + 1'b1;
    end

    assign w_judge      = w_sample && (n_fill == FILL_W'(WIN_LEN));
    assign w_ctrl.judge = w_judge;
    assign w_ctrl.clear = w_clear;
    assign w_ctrl.pos   = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (w_clear) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (w_sample) begin
            r_fill <= n_fill;
            if (w_judge) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // lanes judge each new slot from n_win in the same cycle it is written
    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_win <= n_win;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        always_comb begin
            for (int k = 0; k < WIN_LEN; k++) begin
                w_col[g][k] = n_win[k][g];
            end
        end

        msc_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_column     (w_col[g]),
            .i_load       (w_loadcmd && (i_in.channel == CH_W'(g))),
            .i_load_value (i_in.expected_value),
            .o_stats      (w_stats[g])
        );
    end

    msc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stats   (w_stats),
        .i_push    (w_read),
        .i_channel (i_in.channel),
        .o_full    (w_full),
        .o_out     (o_out)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_LEN))
        else $error("window fill beyond window length");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_judge |=> (r_pos == POSITION_BITS'($past(r_pos) + 1'b1)))
        else $error("position did not advance on a judged word");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_judge && !w_clear) |=> $stable(r_pos))
        else $error("position moved without a judged word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no word pending on output");

endmodule

// File: sim/tb.sv
// ============================================================================
// tb - multichannel signature checker testbench
// Drives snapshot, load, read and clear words into the checker and keeps its
// own copy of the per-channel header and signature statistics. Every
// statistics word that comes out is compared against that copy or a value
// from the directed table. The run goes through that table, then framed
// serial traffic under three idle patterns.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_WORDS = 375;

    typedef struct {
        t_mode             mode;
        logic [WORD_W-1:0] word;
        logic [CH_W-1:0]   chan;
        logic [EXP_W-1:0]  ev;
        bit                typed;
        t_result           want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msc_in_if  in_ch ();
    msc_out_if out_ch ();

    multichannel_signature_checker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model of the checker
    logic [WORD_W-1:0]        win [WIN_LEN];
    int                       fill;
    logic [POSITION_BITS-1:0] wpos;
    logic [EXP_W-1:0]         exp_tab [NUM_CHANNELS];
    logic [SKIP_W-1:0]        skip [NUM_CHANNELS];
    logic [POSITION_BITS-1:0] last_hdr [NUM_CHANNELS];
    logic [POSITION_BITS-1:0] last_gap [NUM_CHANNELS];
    t_lane_stats              lane [NUM_CHANNELS];

    t_result stats_due [$];

    // serial traffic per channel, next bit at lane_left-1
    logic [63:0] lane_buf [NUM_CHANNELS];
    int          lane_left [NUM_CHANNELS];
    int          lane_gap [NUM_CHANNELS];

    int src_idle_pct;
    int sink_idle_pct;
    int failures;
    int checked;
    int stall_cycles;
    int n_sample, n_load, n_read, n_clear;
    int seen_hdr, seen_false, seen_spacing;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // len bits of channel c, MSB first, from window slot first on
    function automatic logic [7:0] serial_bits(input int first, input int len, input int c);
        logic [7:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
            v = {v[6:0], (first + i < WIN_LEN) ? win[first + i][c] : 1'b0};
        return v;
    endfunction

    task automatic clear_run();
        for (int k = 0; k < WIN_LEN; k++)
            win[k] = '0;
        fill = 0;
        wpos = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            skip[c]     = '0;
            last_hdr[c] = '0;
            last_gap[c] = '0;
            lane[c]     = '0;
        end
    endtask

    task automatic judge_lane(input int c);
        logic [POSITION_BITS-1:0] gap;
        logic [7:0]               s1, s2;
        logic [EXP_W-1:0]         ev;
        ev = exp_tab[c];
        if (win[0][c] && skip[c] == 0) begin
            if (serial_bits(0, HDR_LEN, c) == HDR_CODE) begin
                lane[c].headers = bump(lane[c].headers);
                seen_hdr++;
                gap = wpos - last_hdr[c];
                if (gap != last_gap[c] && lane[c].headers > 2) begin
                    lane[c].spacing_err = bump(lane[c].spacing_err);
                    seen_spacing++;
                end
                last_gap[c] = gap;
                last_hdr[c] = wpos;
                s1 = serial_bits(HDR_LEN, SIG_LEN, c);
                s2 = serial_bits(HDR_LEN + SIG_LEN, SIG_LEN, c);
                if (s1[6:0] == ev[15:9])
                    lane[c].sig_match = bump(lane[c].sig_match);
                if (s1[6:0] == ~s2[6:0])
                    lane[c].comp_local = bump(lane[c].comp_local);
                if (s2[6:0] == ev[8:2])
                    lane[c].comp_given = bump(lane[c].comp_given);
                skip[c]          = SKIP_AFTER;
                lane[c].last_sig = s1[6:0];
            end else begin
                lane[c].false_hdrs = bump(lane[c].false_hdrs);
                seen_false++;
            end
        end else if (skip[c] != 0) begin
            skip[c] = skip[c] - 1'b1;
        end
    endtask

    task automatic track_word(input t_mode m, input logic [WORD_W-1:0] w,
                              input logic [CH_W-1:0] ch, input logic [EXP_W-1:0] ev,
                              output bit has_stats, output t_result r);
        has_stats = 1'b0;
        r = '0;
        case (m)
            MODE_SAMPLE: begin
                n_sample++;
                if (fill >= WIN_LEN) begin
                    for (int k = 0; k < WIN_LEN - 1; k++)
                        win[k] = win[k + 1];
                    win[WIN_LEN - 1] = w;
                end else begin
                    win[fill] = w;
                    fill++;
                end
                if (fill == WIN_LEN) begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        if (exp_tab[c] != 0)
                            judge_lane(c);
                    wpos = wpos + 1'b1;
                end
            end
            MODE_LOAD: begin
                n_load++;
                exp_tab[ch] = ev;
            end
            MODE_CLEAR: begin
                n_clear++;
                clear_run();
            end
            default: begin
                n_read++;
                has_stats                  = 1'b1;
                r.read_channel             = ch;
                r.headers_found            = lane[ch].headers;
                r.false_headers            = lane[ch].false_hdrs;
                r.signature_matches        = lane[ch].sig_match;
                r.complement_local_matches = lane[ch].comp_local;
                r.complement_given_matches = lane[ch].comp_given;
                r.spacing_errors           = lane[ch].spacing_err;
                r.newest_signature         = lane[ch].last_sig;
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_word(input t_mode m, input logic [WORD_W-1:0] w,
                              input logic [CH_W-1:0] ch, input logic [EXP_W-1:0] ev,
                              input bit typed, input t_result want);
        bit      has_stats;
        t_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= m;
        in_ch.sample_word    <= w;
        in_ch.channel        <= ch;
        in_ch.expected_value <= ev;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        track_word(m, w, ch, ev, has_stats, r);
        if (has_stats)
            stats_due.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (stats_due.size() != 0);
    endtask

    task automatic refill_lane(input int c);
        logic [6:0]       s1, s2;
        logic [EXP_W-1:0] ev;
        int               pick;
        ev   = exp_tab[c];
        pick = $urandom_range(99);
        if (pick < 55) begin
            s1 = ($urandom_range(3) != 0) ? ev[15:9] : 7'($urandom);
            case ($urandom_range(2))
                0:       s2 = ev[8:2];
                1:       s2 = ~s1;
                default: s2 = 7'($urandom);
            endcase
            // an occasional gap change shows up as a spacing change
            if ($urandom_range(9) == 0)
                lane_gap[c] = $urandom_range(10);
            lane_buf[c]  = 64'({HDR_CODE, s1, s2}) << lane_gap[c];
            lane_left[c] = HDR_LEN + 2 * SIG_LEN + lane_gap[c];
        end else if (pick < 80) begin
            lane_buf[c]  = 64'($urandom_range(255));
            lane_left[c] = HDR_LEN;
        end else if (pick < 90) begin
            // header with one bit flipped
            lane_buf[c]  = 64'(HDR_CODE ^ (8'd1 << $urandom_range(7)));
            lane_left[c] = HDR_LEN;
        end else begin
            lane_buf[c]  = '0;
            lane_left[c] = $urandom_range(1, 6);
        end
    endtask

    function automatic logic [EXP_W-1:0] pick_expected();
        case ($urandom_range(19))
            0, 1, 2: return '0;
            3:       return '1;
            default: return EXP_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // receiver
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge i_clk) begin : stats_check
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.read_channel             = out_ch.read_channel;
            got.headers_found            = out_ch.headers_found;
            got.false_headers            = out_ch.false_headers;
            got.signature_matches        = out_ch.signature_matches;
            got.complement_local_matches = out_ch.complement_local_matches;
            got.complement_given_matches = out_ch.complement_given_matches;
            got.spacing_errors           = out_ch.spacing_errors;
            got.newest_signature         = out_ch.newest_signature;
            if (stats_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%t unexpected statistics word: %p", $realtime, got);
            end else begin
                want = stats_due.pop_front();
                checked++;
                if (got !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%t statistics word mismatch", $realtime);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%t no word moved for %0d cycles, %0d statistics words outstanding",
                     $realtime, STALL_LIMIT, stats_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_stim_row        plan [$];
        t_result          want;
        logic [21:0]      frame;
        t_mode            m;
        logic [WORD_W-1:0] w;
        int               pick;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.mode           = MODE_SAMPLE;
        in_ch.sample_word    = '0;
        in_ch.channel        = '0;
        in_ch.expected_value = '0;
        src_idle_pct         = 17;
        sink_idle_pct        = 76;
        failures             = 0;
        checked              = 0;
        stall_cycles         = 0;
        n_sample = 0; n_load = 0; n_read = 0; n_clear = 0;
        seen_hdr = 0; seen_false = 0; seen_spacing = 0;
        clear_run();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            exp_tab[c]   = '0;
            lane_buf[c]  = '0;
            lane_left[c] = 0;
            lane_gap[c]  = $urandom_range(10);
        end

        // directed: empty stats, one clean frame on channel 0, clear
        want = '0;
        want.read_channel = 5'd31;
        plan.push_back('{MODE_READ, 32'h0, 5'd31, 16'h0, 1'b1, want});
        // signature 0x55 and its complement 0x2A
        plan.push_back('{MODE_LOAD, 32'h0, 5'd0, 16'hAAAB, 1'b0, '0});
        frame = {8'hB1, 7'h55, 7'h2A};
        for (int k = 0; k < WIN_LEN; k++)
            plan.push_back('{MODE_SAMPLE,
                             ((k % 2) ? 32'h0 : 32'hFFFF_FFFE) | {31'h0, frame[21 - k]},
                             5'(k), 16'(k * 16'h0BB3), 1'b0, '0});
        want = '0;
        want.headers_found            = 20'd1;
        want.signature_matches        = 20'd1;
        want.complement_local_matches = 20'd1;
        want.complement_given_matches = 20'd1;
        want.newest_signature         = 7'h55;
        plan.push_back('{MODE_READ, 32'hFFFF_FFFF, 5'd0, 16'hFFFF, 1'b1, want});
        plan.push_back('{MODE_CLEAR, 32'h0, 5'd31, 16'h0, 1'b0, '0});
        plan.push_back('{MODE_READ, 32'h0, 5'd0, 16'h0, 1'b1, '0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            issue_word(plan[i].mode, plan[i].word, plan[i].chan, plan[i].ev,
                       plan[i].typed, plan[i].want);

        for (int c = 0; c < NUM_CHANNELS; c++)
            issue_word(MODE_LOAD, $urandom, 5'(c),
                       ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom_range(1, 65535)),
                       1'b0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 17; sink_idle_pct = 76; end
                1: begin src_idle_pct = 76; sink_idle_pct = 17; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(999);
                if (pick < 720) begin
                    m = MODE_SAMPLE;
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (lane_left[c] == 0)
                            refill_lane(c);
                        lane_left[c]--;
                        w[c] = lane_buf[c][lane_left[c]];
                    end
                end else begin
                    m = (pick < 770) ? MODE_LOAD : (pick < 990) ? MODE_READ : MODE_CLEAR;
                    w = $urandom;
                end
                issue_word(m, w, 5'($urandom_range(31)), pick_expected(), 1'b0, '0);
            end
            // sender waits out every pending statistics word
            hold_until_drained();
        end

        in_ch.valid <= 1'b0;
        while (stats_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (stats_due.size() != 0)
            failures++;

        $display("covered %0d words: %0d snapshots, %0d loads, %0d reads, %0d clears",
                 n_sample + n_load + n_read + n_clear, n_sample, n_load, n_read, n_clear);
        $display("%0d statistics words checked; %0d headers, %0d false headers, %0d spacing changes",
                 checked, seen_hdr, seen_false, seen_spacing);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
design/msc_pkg.sv
design/msc_in_if.sv
design/msc_out_if.sv
design/msc_lane.sv
design/msc_merge.sv
design/multichannel_signature_checker.sv
sim/tb.sv
